// File: rtl/sip_pkg.sv
// shared types, character codes and character helpers for the string to integer parser
package sip_pkg;

    // parse phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    // per-string state without the position counter
    typedef struct packed {
        phase_t      phase;
        logic        negative;
        logic [63:0] accumulator;
        logic [5:0]  active_base;
    } parse_state_t;

    // result of one step
    typedef struct packed {
        logic        produce;
        logic [63:0] value;
        logic [7:0]  end_offset;
    } parse_result_t;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    // digit values and bases
    localparam logic [7:0] DIGIT_NONE  = 8'hFF;
    localparam logic [7:0] LETTER_BASE = 8'd10;
    localparam logic [5:0] BASE_AUTO   = 6'd0;
    localparam logic [5:0] BASE_OCT    = 6'd8;
    localparam logic [5:0] BASE_DEC    = 6'd10;
    localparam logic [5:0] BASE_HEX    = 6'd16;

    // register map
    localparam logic [5:0] BASE_RESET  = BASE_DEC;

    // whitespace test
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
    endfunction

    // digit value of a character, DIGIT_NONE when not a digit or letter
    function automatic logic [7:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = c - CH_LO_A + LETTER_BASE;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = c - CH_UP_A + LETTER_BASE;
        end
        return d;
    endfunction

endpackage

// File: rtl/string_to_integer_parser.sv
// A character is held in the input register, and its result in the result register.
// Throughput: one character per cycle while results are taken; the 64-bit multiply-add
// by the base and the position update are combinational, so each step feeds the next directly.
// Stalls happen only while a result waits, and the input register stalls only when full.
// Reset is synchronous, active low: the parser returns to idle, both stages empty,
// and the base register returns to 10.
module string_to_integer_parser
    import sip_pkg::*;
#(
    parameter int MAX_LEN = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input characters
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] first
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] value, [71:64] end_offset
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int POS_W = $clog2(MAX_LEN + 1);

    logic             in_valid_reg;
    logic [7:0]       in_ch_reg;
    logic             in_first_reg;
    parse_state_t     state_reg;
    parse_state_t     state_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    parse_result_t    step_result;
    logic             out_valid_reg;
    logic [71:0]      out_data_reg;
    logic             advance;
    logic             process;
    logic [5:0]       base_setting;

    // configuration registers
    sip_apb_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .base_setting (base_setting)
    );

    // pipeline moves whenever the result register is free or being emptied
    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_ch_reg    <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    // character step
    sip_parse_step #(
        .MAX_LEN (MAX_LEN),
        .POS_W   (POS_W)
    ) u_step (
        .ch           (in_ch_reg),
        .first        (in_first_reg),
        .base_setting (base_setting),
        .state_cur    (state_reg),
        .pos_cur      (pos_reg),
        .state_next   (state_next),
        .pos_next     (pos_next),
        .result       (step_result)
    );

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_IDLE, negative: 1'b0, accumulator: 64'd0,
                           active_base: 6'd0};
            pos_reg   <= '0;
        end else if (process) begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= process && step_result.produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (process && step_result.produce) begin
            out_data_reg <= {step_result.end_offset, step_result.value};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: rtl/sip_apb_regs.sv
// apb register block holding the number base setting
module sip_apb_regs
    import sip_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [5:0]  base_setting
);

    logic [5:0] base_reg;
    logic [5:0] base_next;
    logic       hit;

    // the base register answers at addresses 0 to 3, where paddr[2] is clear
    assign hit    = (paddr[2] == 1'b0);
    assign pready = 1'b1;

    // write at the access phase
    always_comb begin
        base_next = base_reg;
        if (psel && penable && pwrite && hit) begin
            base_next = pwdata[5:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
        end else begin
            base_reg <= base_next;
        end
    end

    // read data
    assign prdata       = hit ? {26'd0, base_reg} : 32'd0;
    assign base_setting = base_reg;

endmodule

// File: rtl/sip_parse_step.sv
// one character step of the parser: next state and optional result
module sip_parse_step
    import sip_pkg::*;
#(
    parameter int MAX_LEN = 255,
    parameter int POS_W   = 8
) (
    input  logic [7:0]       ch,
    input  logic             first,
    input  logic [5:0]       base_setting,
    input  parse_state_t     state_cur,
    input  logic [POS_W-1:0] pos_cur,
    output parse_state_t     state_next,
    output logic [POS_W-1:0] pos_next,
    output parse_result_t    result
);

    localparam int EXT_W = (POS_W > 8) ? POS_W : 8;

    parse_state_t     st;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pos_adv1;
    logic [POS_W-1:0] pos_adv2;
    logic [7:0]       dval;
    logic             blank;
    logic             is_sign;
    logic             is_x;
    logic             pfx_zero;
    logic [5:0]       signed_base;
    logic             use_digit;
    logic [5:0]       dig_base;
    logic [POS_W-1:0] dig_pos;
    logic             dig_ok;
    logic [63:0]      acc_mac;
    logic [EXT_W-1:0] pos_ext;

    // saturating position increment
    function automatic logic [POS_W-1:0] adv(input logic [POS_W-1:0] p);
        return (p < POS_W'(MAX_LEN)) ? p + 1'b1 : p;
    endfunction

    // a first character restarts the string
    always_comb begin
        st  = state_cur;
        pos = pos_cur;
        if (first) begin
            st.phase       = PH_LEAD;
            st.negative    = 1'b0;
            st.accumulator = 64'd0;
            st.active_base = 6'd0;
            pos            = '0;
        end
    end

    // character classes
    assign blank       = is_blank(ch);
    assign is_sign     = (ch == CH_MINUS) || (ch == CH_PLUS);
    assign is_x        = (ch == CH_LO_X) || (ch == CH_UP_X);
    assign dval        = digit_of(ch);
    assign pfx_zero    = ((base_setting == BASE_AUTO) || (base_setting == BASE_HEX)) &&
                         (ch == CH_ZERO);
    assign signed_base = (base_setting == BASE_AUTO) ? BASE_DEC : base_setting;
    assign pos_adv1    = adv(pos);
    assign pos_adv2    = adv(pos_adv1);

    // pick the digit path, its base and the position it starts from
    always_comb begin
        use_digit = 1'b0;
        dig_base  = st.active_base;
        dig_pos   = pos;
        case (st.phase)
            PH_LEAD, PH_SIGNED: begin
                if ((st.phase == PH_SIGNED || (!blank && !is_sign)) && !pfx_zero) begin
                    use_digit = 1'b1;
                    dig_base  = signed_base;
                end
            end
            PH_ZERO: begin
                if (!is_x) begin
                    use_digit = 1'b1;
                    dig_pos   = pos_adv1;
                end
            end
            PH_DIGITS: begin
                use_digit = 1'b1;
            end
            default: begin
                use_digit = 1'b0;
            end
        endcase
    end

    // digit test and multiply-add
    assign dig_ok  = (dval < {2'b00, dig_base});
    assign acc_mac = st.accumulator * {58'd0, dig_base} + {58'd0, dval[5:0]};

    // next state
    always_comb begin
        state_next = st;
        pos_next   = pos;
        if (use_digit) begin
            state_next.active_base = dig_base;
            if (dig_ok) begin
                state_next.phase       = PH_DIGITS;
                state_next.accumulator = acc_mac;
                pos_next               = adv(dig_pos);
            end else begin
                state_next.phase = PH_IDLE;
                pos_next         = dig_pos;
            end
        end else begin
            case (st.phase)
                PH_LEAD, PH_SIGNED: begin
                    if (st.phase == PH_LEAD && blank) begin
                        pos_next = pos_adv1;
                    end else if (st.phase == PH_LEAD && is_sign) begin
                        state_next.negative = (ch == CH_MINUS);
                        state_next.phase    = PH_SIGNED;
                        pos_next            = pos_adv1;
                    end else begin
                        // leading zero of a base that may take a prefix
                        state_next.active_base =
                            (base_setting == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                        state_next.phase = PH_ZERO;
                    end
                end
                PH_ZERO: begin
                    // hex prefix skipped, both characters counted
                    state_next.active_base = BASE_HEX;
                    state_next.phase       = PH_DIGITS;
                    pos_next               = pos_adv2;
                end
                default: begin
                    state_next = st;
                end
            endcase
        end
    end

    // result on the stop character
    assign pos_ext = EXT_W'(dig_pos);
    always_comb begin
        result.produce    = use_digit && !dig_ok;
        result.value      = st.negative ? (64'd0 - st.accumulator) : st.accumulator;
        result.end_offset = (pos_ext > EXT_W'(255)) ? 8'hFF : pos_ext[7:0];
    end

endmodule

// File: rtl/sip_checker.sv
// port-level checks for the string to integer parser, bound to the top level
module sip_checker #(
    parameter int MAX_LEN = 255
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    localparam int OFF_MAX = (MAX_LEN < 255) ? MAX_LEN : 255;

    // no result is left over from before reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a fresh result follows an input transaction through the input and result registers
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without an input transaction");

    // input side never stalls while the output side takes results
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output ready");

    // the stop offset never passes the length limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[71:64] <= 8'(OFF_MAX)))
        else $error("end offset beyond length limit");

endmodule

bind string_to_integer_parser sip_checker #(.MAX_LEN(MAX_LEN)) u_sip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/parse_result_checker.sv
// result checker for the string to integer parser: predicts results from observed transactions
module parse_result_checker
    import sip_pkg::*;
#(
    parameter int         MAX_LEN       = 255,
    parameter logic [2:0] BASE_REG_ADDR = 3'd0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] first
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // [63:0] value, [71:64] end_offset
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          pending
);

    localparam int NOT_DIGIT        = 99;
    localparam int SHOWN_MISMATCHES = 10;

    typedef struct packed {
        logic [63:0] value;
        logic [7:0]  end_offset;
    } parsed_number_t;

    parsed_number_t expected_numbers[$];

    // shadow of the base register and of the per-string state
    logic [5:0]  base_reg;
    phase_t      ph;
    logic        neg;
    logic [63:0] acc;
    logic [5:0]  cur_base;
    int          pos;

    // value of a digit or letter, NOT_DIGIT for anything else
    function automatic int char_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
        if (c >= CH_LO_A && c <= CH_LO_Z) return int'(c) - int'(CH_LO_A) + 10;
        if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c) - int'(CH_UP_A) + 10;
        return NOT_DIGIT;
    endfunction

    // saturating position count
    task automatic bump();
        if (pos < MAX_LEN) pos++;
    endtask

    // digit phase: accumulate, or close the string and give its number
    task automatic close_or_accumulate(input logic [7:0] c, output bit done,
                                       output parsed_number_t num);
        int d;
        d = char_value(c);
        done = 1'b0;
        num = '0;
        if (d < int'(cur_base)) begin
            acc = acc * 64'(cur_base) + 64'(d);
            bump();
        end else begin
            num.value = neg ? 64'd0 - acc : acc;
            num.end_offset = (pos > 255) ? 8'd255 : 8'(pos);
            ph = PH_IDLE;
            done = 1'b1;
        end
    endtask

    // first character after the optional sign picks the working base
    task automatic after_sign(input logic [7:0] c, output bit done, output parsed_number_t num);
        done = 1'b0;
        num = '0;
        if ((base_reg == BASE_AUTO || base_reg == BASE_HEX) && c == CH_ZERO) begin
            cur_base = (base_reg == BASE_AUTO) ? BASE_OCT : BASE_HEX;
            ph = PH_ZERO;
        end else begin
            cur_base = (base_reg == BASE_AUTO) ? BASE_DEC : base_reg;
            ph = PH_DIGITS;
            close_or_accumulate(c, done, num);
        end
    endtask

    // one character through the parser
    task automatic parse_char(input logic [7:0] c, input logic first_flag, output bit done,
                              output parsed_number_t num);
        done = 1'b0;
        num = '0;
        if (first_flag) begin
            ph = PH_LEAD;
            neg = 1'b0;
            acc = '0;
            cur_base = '0;
            pos = 0;
        end
        case (ph)
            PH_LEAD: begin
                if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) begin
                    bump();
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    neg = (c == CH_MINUS);
                    bump();
                    ph = PH_SIGNED;
                end else begin
                    after_sign(c, done, num);
                end
            end
            PH_SIGNED: after_sign(c, done, num);
            PH_ZERO: begin
                if (c == CH_LO_X || c == CH_UP_X) begin
                    // both prefix characters count toward the offset
                    cur_base = BASE_HEX;
                    bump();
                    bump();
                    ph = PH_DIGITS;
                end else begin
                    // the leading zero is an ordinary digit
                    bump();
                    ph = PH_DIGITS;
                    close_or_accumulate(c, done, num);
                end
            end
            PH_DIGITS: close_or_accumulate(c, done, num);
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        if (mismatch_count < SHOWN_MISMATCHES)
            $display("%0t: %s: expected %0h, got %0h", $time, what, want_v, got_v);
        mismatch_count++;
    endtask

    // watch register writes and both channels
    always @(posedge aclk) begin
        bit             done;
        parsed_number_t want;
        parsed_number_t got;
        if (!aresetn) begin
            base_reg = BASE_DEC;
            ph = PH_IDLE;
            neg = 1'b0;
            acc = '0;
            cur_base = '0;
            pos = 0;
            expected_numbers.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == BASE_REG_ADDR)
                base_reg = pwdata[5:0];
            if (s_tvalid && s_tready) begin
                parse_char(s_tdata, s_tuser, done, want);
                if (done) expected_numbers.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.value = m_tdata[63:0];
                got.end_offset = m_tdata[71:64];
                if (expected_numbers.size() == 0) begin
                    note_mismatch("result transaction with none expected", '0, got.value);
                end else begin
                    want = expected_numbers.pop_front();
                    if (got.value != want.value)
                        note_mismatch("value", want.value, got.value);
                    if (got.end_offset != want.end_offset)
                        note_mismatch("end_offset", 64'(want.end_offset), 64'(got.end_offset));
                end
            end
        end
        pending = expected_numbers.size();
    end

endmodule

// File: test/testbench.sv
// top of the string to integer parser test: clock, reset, stimulus and verdict
module testbench;
    import sip_pkg::*;

    localparam logic [2:0] BASE_ADDR   = 3'd0;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam int         PHASES      = 10;
    localparam int         PHASE_ITEMS = 125;
    localparam int         LONG_HOLD   = 300;
    localparam int         SETTLE      = 4;
    localparam int         TIMEOUT     = 4000000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // [7:0] ch
    logic        s_tuser  = 1'b0;  // [0] first
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;          // [63:0] value, [71:64] end_offset
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    int          mismatch_count;
    int          pending;

    // stimulus control
    bit          tx_idle_on = 1'b1;
    bit          hold_request = 1'b0;
    int          items_sent = 0;

    // receiver pacing state
    bit          hold_served = 1'b0;
    int          rx_stall = 0;
    int          rx_run = 0;

    string_to_integer_parser dut (.*);

    parse_result_checker #(.BASE_REG_ADDR(BASE_ADDR)) result_check (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return 8'(int'(CH_ZERO) + d);
        return 8'(int'($urandom_range(1) ? CH_LO_A : CH_UP_A) + d - 10);
    endfunction

    // any byte that is neither a digit nor a letter
    function automatic logic [7:0] stop_char();
        case ($urandom_range(3))
            0: return 8'($urandom_range(0, 47));
            1: return 8'($urandom_range(58, 64));
            2: return 8'($urandom_range(91, 96));
            default: return 8'($urandom_range(123, 255));
        endcase
    endfunction

    // result side: random stalls, stall-free runs and one long hold-off
    always @(negedge aclk) begin
        if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            rx_stall = LONG_HOLD;
            rx_run = 1;
        end
        if (rx_stall == 0 && rx_run == 0) begin
            if ($urandom_range(9) < 2) begin
                rx_run = $urandom_range(20, 80);
            end else begin
                rx_stall = idle_len();
                rx_run = $urandom_range(1, 4);
            end
        end
        if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_tready <= 1'b1;
            rx_run--;
        end
    end

    // one character transaction, called and returning at a falling edge
    task automatic send_char(input logic [7:0] c, input logic first_flag);
        int gap;
        s_tdata <= c;
        s_tuser <= first_flag;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        if (tx_idle_on) begin
            gap = idle_len();
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    // register write through setup and access cycles
    task automatic write_base(input logic [5:0] base);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= BASE_ADDR;
        pwdata <= {26'($urandom), base};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // stop offering and wait until every number has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // one random string: mostly well formed, some noise
    task automatic send_string(input logic [5:0] base, input bit long_digits);
        logic [7:0] s[$];
        int         eff;
        int         n;
        int         r;
        r = $urandom_range(99);
        if (r < 8) begin
            // noise with arbitrary bytes and first flags
            n = $urandom_range(1, 8);
            repeat (n) send_char(8'($urandom), 1'($urandom));
            return;
        end
        // leading whitespace and sign
        if ($urandom_range(3) == 0) begin
            n = $urandom_range(1, 3);
            repeat (n) s.push_back(pick_blank());
        end
        r = $urandom_range(2);
        if (r == 1) s.push_back(CH_PLUS);
        if (r == 2) s.push_back(CH_MINUS);
        // prefix
        eff = (base == BASE_AUTO) ? 10 : int'(base);
        if ((base == BASE_AUTO || base == BASE_HEX) && $urandom_range(1)) begin
            s.push_back(CH_ZERO);
            if ($urandom_range(3) != 0) begin
                s.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
                eff = 16;
            end else if (base == BASE_AUTO) begin
                eff = 8;
            end
        end else if (base != BASE_AUTO && base != BASE_HEX && $urandom_range(9) == 0) begin
            s.push_back(CH_ZERO);
            s.push_back(CH_LO_X);
        end
        if (eff > 36) eff = 36;
        // digits below the working base
        if (long_digits) n = $urandom_range(250, 280);
        else if ($urandom_range(4) == 0) n = $urandom_range(12, 24);
        else n = $urandom_range(0, 8);
        repeat (n) s.push_back(digit_char($urandom_range(eff - 1)));
        // terminator, sometimes none so the next string drops this one
        r = $urandom_range(9);
        if (r < 4) s.push_back(CH_NUL);
        else if (r < 7) s.push_back(stop_char());
        else if (r < 9) s.push_back(eff < 36 ? digit_char($urandom_range(eff, 35)) : CH_NUL);
        foreach (s[i]) send_char(s[i], i == 0);
    endtask

    function automatic logic [5:0] phase_base(input int p);
        case (p)
            0: return BASE_AUTO;
            1: return BASE_HEX;
            2: return 6'd36;
            3: return 6'd63;
            4: return 6'd1;
            5: return 6'd2;
            6: return BASE_OCT;
            7: return 6'($urandom_range(3, 35));
            8: return 6'($urandom_range(37, 62));
            default: return BASE_DEC;
        endcase
    endfunction

    // stimulus
    initial begin : stimulus
        logic [5:0] base;
        int         start;
        int         strings;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset base: ignored char while idle, blanks and sign, bare sign,
        // dropped string, stop byte at the top of the range
        send_char(CH_UP_A, 1'b0);
        send_char(CH_SPACE, 1'b1);
        send_char(CH_TAB, 1'b0);
        send_char(CH_MINUS, 1'b0);
        send_char(CH_NINE, 1'b0);
        send_char(CH_LO_Z, 1'b0);
        send_char(CH_PLUS, 1'b1);
        send_char(CH_NUL, 1'b0);
        send_char(digit_char(7), 1'b1);
        send_char(digit_char(5), 1'b1);
        send_char(CH_NUL, 1'b0);
        send_char(8'hFF, 1'b1);
        drain_results();

        // detected base: hex prefix, octal, bare prefix
        write_base(BASE_AUTO);
        send_char(CH_ZERO, 1'b1);
        send_char(CH_LO_X, 1'b0);
        send_char(digit_char(1), 1'b0);
        send_char(CH_UP_A + 8'd5, 1'b0);
        send_char(CH_NUL, 1'b0);
        send_char(CH_MINUS, 1'b1);
        send_char(CH_ZERO, 1'b0);
        send_char(digit_char(1), 1'b0);
        send_char(digit_char(7), 1'b0);
        send_char(CH_SEMI, 1'b0);
        send_char(CH_ZERO, 1'b1);
        send_char(CH_UP_X, 1'b0);
        send_char(CH_LO_A + 8'd6, 1'b0);
        drain_results();

        // random phases, one per base setting
        for (int p = 0; p < PHASES; p++) begin
            base = phase_base(p);
            write_base(base);
            tx_idle_on = (p % 3 != 0);
            if (p == 0) hold_request = 1'b1;
            start = items_sent;
            strings = 0;
            while (items_sent - start < PHASE_ITEMS) begin
                send_string(base, (p == 2 && strings == 0) || $urandom_range(299) == 0);
                strings++;
            end
            drain_results();
        end

        if (mismatch_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #TIMEOUT;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: string_to_integer_parser.f
rtl/sip_pkg.sv
rtl/sip_apb_regs.sv
rtl/sip_parse_step.sv
rtl/string_to_integer_parser.sv
rtl/sip_checker.sv
test/parse_result_checker.sv
test/testbench.sv
